/* rtl/mtp_pkg.sv */
`timescale 1ns / 1ps

package mtp_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int ANGLE_BITS_DEF = 16;

   localparam int KIND_BITS      = 2;
   localparam int CORE_BITS      = 12;
   localparam int RADIUS_BITS    = 17;
   localparam int ACC_BITS       = 32;
   localparam int CORDIC_STEPS   = 28;
   localparam int PRESCALE_SHIFT = 20;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = '1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CORE_ROW = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CORE_COL = 1'b1;

   typedef logic [ACC_BITS-1:0] acc_type;

   // Angles in units of 2^-32 of a full turn.
   localparam acc_type TURN_ZERO     = 32'h0000_0000;
   localparam acc_type TURN_QUARTER  = 32'h4000_0000;
   localparam acc_type TURN_HALF     = 32'h8000_0000;
   localparam acc_type TURN_3QUARTER = 32'hC000_0000;

   // atan(2^-i) in units of 2^-32 turn.
   localparam acc_type ATAN_TURNS [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5
   };

   // Sideband that travels with a transaction down the row of cells.
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic                 fixed;
      acc_type              acc;
   } tag_type;

   // Radicand is 256 * (d0^2 + d1^2), rounded up to an even number of bits.
   function automatic int root_bits(input int coord_bits);
      return coord_bits + 5;
   endfunction

   function automatic int rad_bits(input int coord_bits);
      return 2 * (coord_bits + 5);
   endfunction

   function automatic int rem_bits(input int coord_bits);
      return coord_bits + 8;
   endfunction

   // Signed width of the scaled CORDIC vector, including the growth of the rotations.
   function automatic int vec_bits(input int coord_bits);
      return coord_bits + PRESCALE_SHIFT + 3;
   endfunction

endpackage

/* rtl/mtp_if.sv */
`timescale 1ns / 1ps

interface mtp_req_if #(
   parameter int COORD_BITS = mtp_pkg::COORD_BITS_DEF
);
   import mtp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  kind;
   logic [COORD_BITS-1:0] pos_a;
   logic [COORD_BITS-1:0] pos_b;

   modport source (output valid, kind, pos_a, pos_b, input ready);
   modport sink   (input valid, kind, pos_a, pos_b, output ready);
endinterface

interface mtp_rsp_if #(
   parameter int ANGLE_BITS = mtp_pkg::ANGLE_BITS_DEF
);
   import mtp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   kind_out;
   logic [RADIUS_BITS-1:0] radius;
   logic [ANGLE_BITS-1:0]  angle;

   modport source (output valid, kind_out, radius, angle, input ready);
   modport sink   (input valid, kind_out, radius, angle, output ready);
endinterface

/* rtl/mtp_cell.sv */
`timescale 1ns / 1ps

module mtp_cell #(
   parameter int COORD_BITS = mtp_pkg::COORD_BITS_DEF,
   parameter int STAGE      = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  mtp_pkg::tag_type              up_tag,
   input  logic signed [COORD_BITS+22:0] up_x,
   input  logic signed [COORD_BITS+22:0] up_y,
   input  logic [2*COORD_BITS+9:0]       up_rad,
   input  logic [COORD_BITS+7:0]         up_rem,
   input  logic [COORD_BITS+4:0]         up_root,
   output logic                          down_valid,
   input  logic                          down_ready,
   output mtp_pkg::tag_type              down_tag,
   output logic signed [COORD_BITS+22:0] down_x,
   output logic signed [COORD_BITS+22:0] down_y,
   output logic [2*COORD_BITS+9:0]       down_rad,
   output logic [COORD_BITS+7:0]         down_rem,
   output logic [COORD_BITS+4:0]         down_root
);
   import mtp_pkg::*;

   localparam int VEC_BITS  = vec_bits(COORD_BITS);
   localparam int RAD_BITS  = rad_bits(COORD_BITS);
   localparam int REM_BITS  = rem_bits(COORD_BITS);
   localparam int ROOT_BITS = root_bits(COORD_BITS);

   logic                       valid_ff;
   tag_type                    tag_ff, tag_in;
   logic signed [VEC_BITS-1:0] x_ff, x_in;
   logic signed [VEC_BITS-1:0] y_ff, y_in;
   logic [RAD_BITS-1:0]        rad_ff, rad_in;
   logic [REM_BITS-1:0]        rem_ff, rem_in;
   logic [ROOT_BITS-1:0]       root_ff, root_in;

   assign up_ready = !valid_ff || down_ready;

   // One micro-rotation; vectors on an axis already carry their exact angle.
   always_comb begin
      tag_in = up_tag;
      x_in   = up_x;
      y_in   = up_y;
      if (!up_tag.fixed) begin
         if (up_y > 0) begin
            x_in       = up_x + (up_y >>> STAGE);
            y_in       = up_y - (up_x >>> STAGE);
            tag_in.acc = up_tag.acc + ATAN_TURNS[STAGE];
         end else begin
            x_in       = up_x - (up_y >>> STAGE);
            y_in       = up_y + (up_x >>> STAGE);
            tag_in.acc = up_tag.acc - ATAN_TURNS[STAGE];
         end
      end
   end

   // One bit of the restoring square root, while radicand bits remain.
   generate
      if (STAGE < ROOT_BITS) begin : g_root
         logic [REM_BITS-1:0] shifted;
         logic [REM_BITS-1:0] trial;

         always_comb begin
            shifted = {up_rem[REM_BITS-3:0], up_rad[RAD_BITS-1 -: 2]};
            trial   = REM_BITS'({up_root, 2'b01});
            rad_in  = up_rad << 2;
            if (shifted >= trial) begin
               rem_in  = shifted - trial;
               root_in = {up_root[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = shifted;
               root_in = {up_root[ROOT_BITS-2:0], 1'b0};
            end
         end
      end else begin : g_pass
         assign rad_in  = up_rad;
         assign rem_in  = up_rem;
         assign root_in = up_root;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         tag_ff  <= tag_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_tag   = tag_ff;
   assign down_x     = x_ff;
   assign down_y     = y_ff;
   assign down_rad   = rad_ff;
   assign down_rem   = rem_ff;
   assign down_root  = root_ff;

endmodule

/* rtl/minutia_to_polar_about_core.sv */
`timescale 1ns / 1ps

// Channel    Direction  Payload                              Transfer
// req_chan   in         kind, pos_a, pos_b                   valid && ready
// rsp_chan   out        kind_out, radius, angle              valid && ready
// csr_*      in         csr_index, csr_wdata                 csr_we
//
// Accepts one transaction per cycle unless the output stalls; it has three entry stages
// (offset, squares and initial vector, radicand), 28 CORDIC cells and the output register.
// The first 17 cells also carry the 17-step square root, one result bit per cell.
// Each stage holds its own valid bit, so bubbles close up while the output stalls.
// Minutiae on the core are consumed and give no result. Reset clears the core registers.

module minutia_to_polar_about_core #(
   parameter int COORD_BITS = mtp_pkg::COORD_BITS_DEF,
   parameter int ANGLE_BITS = mtp_pkg::ANGLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   mtp_req_if.sink                             req_chan,
   mtp_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [mtp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mtp_pkg::CORE_BITS-1:0]       csr_wdata
);
   import mtp_pkg::*;

   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int SUM_BITS   = SQ_BITS + 1;
   localparam int VEC_BITS   = vec_bits(COORD_BITS);
   localparam int RAD_BITS   = rad_bits(COORD_BITS);
   localparam int REM_BITS   = rem_bits(COORD_BITS);
   localparam int ROOT_BITS  = root_bits(COORD_BITS);
   localparam int MASK_BITS  = (COORD_BITS > CORE_BITS) ? COORD_BITS : CORE_BITS;
   localparam int WIDE_BITS  = (ROOT_BITS > RADIUS_BITS) ? ROOT_BITS : RADIUS_BITS;
   localparam acc_type ANGLE_ROUND = acc_type'(1) << (ACC_BITS - 1 - ANGLE_BITS);

   // Configuration registers.
   logic [CORE_BITS-1:0] core_row_ff, core_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         core_row_ff <= '0;
         core_col_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CORE_ROW: core_row_ff <= csr_wdata;
            CSR_CORE_COL: core_col_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [MASK_BITS-1:0]  core_row_wide, core_col_wide;
   logic [COORD_BITS-1:0] core_row_m, core_col_m;

   assign core_row_wide = MASK_BITS'(core_row_ff);
   assign core_col_wide = MASK_BITS'(core_col_ff);
   assign core_row_m    = core_row_wide[COORD_BITS-1:0];
   assign core_col_m    = core_col_wide[COORD_BITS-1:0];

   // Stage 0: offsets from the core.
   logic                        p0_valid_ff, p0_ready, p1_ready;
   logic [KIND_BITS-1:0]        p0_kind_ff;
   logic signed [DIFF_BITS-1:0] p0_d0_ff, p0_d1_ff, p0_d0_in, p0_d1_in;
   logic                        on_core;

   assign p0_d0_in = $signed({1'b0, req_chan.pos_a}) - $signed({1'b0, core_row_m});
   assign p0_d1_in = $signed({1'b0, req_chan.pos_b}) - $signed({1'b0, core_col_m});
   assign on_core  = (req_chan.pos_a == core_row_m) && (req_chan.pos_b == core_col_m);
   assign p0_ready = !p0_valid_ff || p1_ready;
   assign req_chan.ready = p0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (p0_ready) begin
         p0_valid_ff <= req_chan.valid && !on_core;
      end
      if (p0_ready && req_chan.valid) begin
         p0_kind_ff <= req_chan.kind;
         p0_d0_ff   <= p0_d0_in;
         p0_d1_ff   <= p0_d1_in;
      end
   end

   // Stage 1: squares for the radius, starting vector and angle for the CORDIC.
   logic                          p1_valid_ff, p2_ready;
   logic [SQ_BITS-1:0]            p1_sq0_ff, p1_sq1_ff;
   tag_type                       p1_tag_ff, p1_tag_in;
   logic signed [VEC_BITS-1:0]    p1_x_ff, p1_y_ff, p1_x_in, p1_y_in;
   logic signed [2*DIFF_BITS-1:0] prod0, prod1;
   logic signed [VEC_BITS-1:0]    d0_ext, d1_ext;

   assign prod0    = p0_d0_ff * p0_d0_ff;
   assign prod1    = p0_d1_ff * p0_d1_ff;
   assign d0_ext   = VEC_BITS'(p0_d0_ff);
   assign d1_ext   = VEC_BITS'(p0_d1_ff);
   assign p1_ready = !p1_valid_ff || p2_ready;

   always_comb begin
      p1_tag_in.kind  = p0_kind_ff;
      p1_tag_in.fixed = 1'b1;
      if (p0_d0_ff == '0) begin
         p1_tag_in.acc = (p0_d1_ff > 0) ? TURN_ZERO : TURN_HALF;
      end else if (p0_d1_ff == '0) begin
         p1_tag_in.acc = (p0_d0_ff > 0) ? TURN_QUARTER : TURN_3QUARTER;
      end else begin
         p1_tag_in.fixed = 1'b0;
         p1_tag_in.acc   = (p0_d1_ff < 0) ? TURN_HALF : TURN_ZERO;
      end
      // The vector is (d1, d0); a negative first component is turned by half a turn.
      if (p0_d1_ff < 0) begin
         p1_x_in = (-d1_ext) <<< PRESCALE_SHIFT;
         p1_y_in = (-d0_ext) <<< PRESCALE_SHIFT;
      end else begin
         p1_x_in = d1_ext <<< PRESCALE_SHIFT;
         p1_y_in = d0_ext <<< PRESCALE_SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (p1_ready) begin
         p1_valid_ff <= p0_valid_ff;
      end
      if (p1_ready && p0_valid_ff) begin
         p1_sq0_ff <= prod0[SQ_BITS-1:0];
         p1_sq1_ff <= prod1[SQ_BITS-1:0];
         p1_tag_ff <= p1_tag_in;
         p1_x_ff   <= p1_x_in;
         p1_y_ff   <= p1_y_in;
      end
   end

   // Stage 2: radicand.
   logic                       p2_valid_ff;
   logic [RAD_BITS-1:0]        p2_rad_ff;
   tag_type                    p2_tag_ff;
   logic signed [VEC_BITS-1:0] p2_x_ff, p2_y_ff;
   logic [SUM_BITS-1:0]        sq_sum;

   assign sq_sum = SUM_BITS'(p1_sq0_ff) + SUM_BITS'(p1_sq1_ff);

   logic                       chain_valid [CORDIC_STEPS+1];
   logic                       chain_ready [CORDIC_STEPS+1];
   tag_type                    chain_tag   [CORDIC_STEPS+1];
   logic signed [VEC_BITS-1:0] chain_x     [CORDIC_STEPS+1];
   logic signed [VEC_BITS-1:0] chain_y     [CORDIC_STEPS+1];
   logic [RAD_BITS-1:0]        chain_rad   [CORDIC_STEPS+1];
   logic [REM_BITS-1:0]        chain_rem   [CORDIC_STEPS+1];
   logic [ROOT_BITS-1:0]       chain_root  [CORDIC_STEPS+1];

   assign p2_ready = !p2_valid_ff || chain_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (p2_ready) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (p2_ready && p1_valid_ff) begin
         p2_rad_ff <= RAD_BITS'({sq_sum, 8'h00});
         p2_tag_ff <= p1_tag_ff;
         p2_x_ff   <= p1_x_ff;
         p2_y_ff   <= p1_y_ff;
      end
   end

   assign chain_valid[0] = p2_valid_ff;
   assign chain_tag[0]   = p2_tag_ff;
   assign chain_x[0]     = p2_x_ff;
   assign chain_y[0]     = p2_y_ff;
   assign chain_rad[0]   = p2_rad_ff;
   assign chain_rem[0]   = '0;
   assign chain_root[0]  = '0;

   generate
      for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cell
         mtp_cell #(
            .COORD_BITS (COORD_BITS),
            .STAGE      (s)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .up_valid   (chain_valid[s]),
            .up_ready   (chain_ready[s]),
            .up_tag     (chain_tag[s]),
            .up_x       (chain_x[s]),
            .up_y       (chain_y[s]),
            .up_rad     (chain_rad[s]),
            .up_rem     (chain_rem[s]),
            .up_root    (chain_root[s]),
            .down_valid (chain_valid[s+1]),
            .down_ready (chain_ready[s+1]),
            .down_tag   (chain_tag[s+1]),
            .down_x     (chain_x[s+1]),
            .down_y     (chain_y[s+1]),
            .down_rad   (chain_rad[s+1]),
            .down_rem   (chain_rem[s+1]),
            .down_root  (chain_root[s+1])
         );
      end
   endgenerate

   // Output register: angle rounding and radius saturation.
   logic                   rsp_valid_ff, out_ready;
   logic [KIND_BITS-1:0]   rsp_kind_ff;
   logic [RADIUS_BITS-1:0] rsp_radius_ff, radius_in;
   logic [ANGLE_BITS-1:0]  rsp_angle_ff;
   acc_type                angle_sum;
   logic [WIDE_BITS-1:0]   root_wide;

   assign angle_sum = chain_tag[CORDIC_STEPS].acc + ANGLE_ROUND;
   assign root_wide = WIDE_BITS'(chain_root[CORDIC_STEPS]);
   assign radius_in = (root_wide > WIDE_BITS'(RADIUS_MAX)) ? RADIUS_MAX
                                                           : root_wide[RADIUS_BITS-1:0];
   assign out_ready = !rsp_valid_ff || rsp_chan.ready;
   assign chain_ready[CORDIC_STEPS] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= chain_valid[CORDIC_STEPS];
      end
      if (out_ready && chain_valid[CORDIC_STEPS]) begin
         rsp_kind_ff   <= chain_tag[CORDIC_STEPS].kind;
         rsp_radius_ff <= radius_in;
         rsp_angle_ff  <= angle_sum[ACC_BITS-1 -: ANGLE_BITS];
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.kind_out = rsp_kind_ff;
   assign rsp_chan.radius   = rsp_radius_ff;
   assign rsp_chan.angle    = rsp_angle_ff;

   // A minutia on the core must not enter the pipeline.
   a_core_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && on_core) |=> !p0_valid_ff)
      else $error("minutia on the core entered the pipeline");

   // Any point off the core lies at least one pixel away, so the radius is at least 1.0.
   a_radius_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_radius_ff >= RADIUS_BITS'(16)))
      else $error("radius below one pixel for a point off the core");

   // A stalled entry stage must keep its offsets.
   a_entry_hold: assert property (@(posedge clock) disable iff (reset)
      (p0_valid_ff && !p1_ready) |=>
         (p0_valid_ff && $stable(p0_d0_ff) && $stable(p0_d1_ff)))
      else $error("entry stage lost its transaction during a stall");

endmodule
